@@ hdl/nsta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsta_pkg
// Types and constants shared by the nine-slice texel address pipeline.
// ----------------------------------------------------------------------------
package nsta_pkg;

    // field widths
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int ADDR_W      = 24;
    localparam int REG_W       = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int SIGNED_W    = 15;
    localparam int NUM_W       = 2 * COORD_W;

    // one quotient bit per divider stage
    localparam int DIV_STAGES   = COORD_W;
    localparam int PIPE_LATENCY = DIV_STAGES + 5;

    // fixed border of the compact variant
    localparam int COMPACT_BORDER = 4;

    // axis slots
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;

    // register map, word index
    typedef enum logic [2:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_MARGIN_LEFT   = 3'd2,
        REG_MARGIN_TOP    = 3'd3,
        REG_MARGIN_RIGHT  = 3'd4,
        REG_MARGIN_BOTTOM = 3'd5,
        REG_TILE_CENTRE   = 3'd6,
        REG_COMPACT_MODE  = 3'd7
    } cfg_reg_t;

    // which slice a coordinate falls in
    typedef enum logic [1:0] {
        RGN_LOW  = 2'd0,
        RGN_HIGH = 2'd1,
        RGN_MID  = 2'd2,
        RGN_FLAT = 2'd3
    } region_t;

    // per-axis data carried alongside the divider
    typedef struct packed {
        region_t              region;
        logic                 tiled;
        logic [COORD_W-1:0]   base;
        logic [SIGNED_W-1:0]  corner;
    } axis_side_t;

    typedef axis_side_t [1:0] side_pair_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] quot;
        logic [DIM_W-1:0]   den;
    } div_lane_t;

endpackage

@@ hdl/nine_slice_texel_address.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_slice_texel_address
// Maps a destination pixel of a nine-slice panel to a source texel and its
// linear address, with stretched or tiled edges and a compact 4-pixel mode.
// ----------------------------------------------------------------------------
// usage
//   configuration: APB-style port, registers at byte address 4*index, one
//   write per setup/access pair, pready always high; write only while idle
//   input: a transfer is taken at each rising edge with start high and busy
//   low; busy is always low, so one pixel may be issued every cycle
//   output: done pulses for one cycle with source_x, source_y and
//   source_address; the receiver takes every result and cannot stall
//   pipeline: 17 register stages from the start transfer to the result
//   (input register, slice decode, multiply, 12 divider stages, clamp,
//   address multiply)
//   throughput: one pixel per cycle; the 12-stage restoring divider shared
//   by stretch and tile produces one quotient bit per stage
//   reset: configuration returns to a 16x16 texture with 5-texel margins,
//   stretch mode; all pipeline valids clear, in-flight pixels are dropped
// ----------------------------------------------------------------------------
module nine_slice_texel_address
    import nsta_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [REG_W-1:0]       pwdata,
    output logic [REG_W-1:0]       prdata,
    output logic                   pready,
    // pixel command
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_W-1:0]     dest_x,
    input  logic [COORD_W-1:0]     dest_y,
    input  logic [DIM_W-1:0]       dest_width,
    input  logic [DIM_W-1:0]       dest_height,
    // texel result
    output logic                   done,
    output logic [COORD_W-1:0]     source_x,
    output logic [COORD_W-1:0]     source_y,
    output logic [ADDR_W-1:0]      source_address
);

    localparam logic [DIM_W-1:0]   MAX_DIM     = DIM_W'(MAX_DIMENSION);
    localparam logic [DIM_W-1:0]   TWO_BORDERS = DIM_W'(2 * COMPACT_BORDER);
    localparam logic [COORD_W-1:0] BORDER      = COORD_W'(COMPACT_BORDER);

    // saturate a size to [1, MAX_DIMENSION]
    function automatic logic [DIM_W-1:0] sat_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // configuration registers
    logic [DIM_W-1:0]   source_width_reg;
    logic [DIM_W-1:0]   source_height_reg;
    logic [COORD_W-1:0] margin_left_reg;
    logic [COORD_W-1:0] margin_top_reg;
    logic [COORD_W-1:0] margin_right_reg;
    logic [COORD_W-1:0] margin_bottom_reg;
    logic               tile_centre_reg;
    logic               compact_mode_reg;

    logic     cfg_write;
    cfg_reg_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= DIM_W'(16);
            source_height_reg <= DIM_W'(16);
            margin_left_reg   <= COORD_W'(5);
            margin_top_reg    <= COORD_W'(5);
            margin_right_reg  <= COORD_W'(5);
            margin_bottom_reg <= COORD_W'(5);
            tile_centre_reg   <= 1'b0;
            compact_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= pwdata[DIM_W-1:0];
                REG_MARGIN_LEFT:   margin_left_reg   <= pwdata[COORD_W-1:0];
                REG_MARGIN_TOP:    margin_top_reg    <= pwdata[COORD_W-1:0];
                REG_MARGIN_RIGHT:  margin_right_reg  <= pwdata[COORD_W-1:0];
                REG_MARGIN_BOTTOM: margin_bottom_reg <= pwdata[COORD_W-1:0];
                REG_TILE_CENTRE:   tile_centre_reg   <= pwdata[0];
                REG_COMPACT_MODE:  compact_mode_reg  <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (cfg_index)
            REG_SOURCE_WIDTH:  prdata = REG_W'(source_width_reg);
            REG_SOURCE_HEIGHT: prdata = REG_W'(source_height_reg);
            REG_MARGIN_LEFT:   prdata = REG_W'(margin_left_reg);
            REG_MARGIN_TOP:    prdata = REG_W'(margin_top_reg);
            REG_MARGIN_RIGHT:  prdata = REG_W'(margin_right_reg);
            REG_MARGIN_BOTTOM: prdata = REG_W'(margin_bottom_reg);
            REG_TILE_CENTRE:   prdata = REG_W'(tile_centre_reg);
            REG_COMPACT_MODE:  prdata = REG_W'(compact_mode_reg);
            default:           prdata = '0;
        endcase
    end

    // static texture checks for the compact variant
    logic [DIM_W-1:0] sw_sat;
    logic [DIM_W-1:0] sh_sat;
    logic             cfg_compact_ok;

    assign sw_sat = sat_size(source_width_reg);
    assign sh_sat = sat_size(source_height_reg);

    assign cfg_compact_ok = compact_mode_reg
        && (sw_sat > TWO_BORDERS) && (sh_sat > TWO_BORDERS)
        && (margin_left_reg >= BORDER) && (margin_top_reg >= BORDER)
        && (margin_right_reg >= BORDER) && (margin_bottom_reg >= BORDER)
        && ((DIM_W'(margin_left_reg) + DIM_W'(margin_right_reg)) < sw_sat)
        && ((DIM_W'(margin_top_reg) + DIM_W'(margin_bottom_reg)) < sh_sat);

    // stage 1: input register with size saturation
    logic               start_xfer;
    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [DIM_W-1:0]   s1_w_reg;
    logic [DIM_W-1:0]   s1_h_reg;
    logic               s1_compact_reg;
    logic               s1_compact_next;

    assign busy       = 1'b0;
    assign start_xfer = start & ~busy;

    assign s1_compact_next = cfg_compact_ok
        && (dest_width > TWO_BORDERS) && (dest_height > TWO_BORDERS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg       <= dest_x;
        s1_y_reg       <= dest_y;
        s1_w_reg       <= sat_size(dest_width);
        s1_h_reg       <= sat_size(dest_height);
        s1_compact_reg <= s1_compact_next;
    end

    // per-axis operands
    logic [1:0][COORD_W-1:0] ax_d;
    logic [1:0][DIM_W-1:0]   ax_dn;
    logic [1:0][DIM_W-1:0]   ax_sn;
    logic [1:0][COORD_W-1:0] ax_a;
    logic [1:0][COORD_W-1:0] ax_b;

    always_comb
    begin
        ax_d[AXIS_X]  = s1_x_reg;
        ax_d[AXIS_Y]  = s1_y_reg;
        ax_dn[AXIS_X] = s1_w_reg;
        ax_dn[AXIS_Y] = s1_h_reg;
        ax_sn[AXIS_X] = sw_sat;
        ax_sn[AXIS_Y] = sh_sat;
        ax_a[AXIS_X]  = margin_left_reg;
        ax_a[AXIS_Y]  = margin_top_reg;
        ax_b[AXIS_X]  = margin_right_reg;
        ax_b[AXIS_Y]  = margin_bottom_reg;
    end

    // stage 2: slice decode
    logic                    s2_valid_reg;
    side_pair_t              s2_side_reg;
    side_pair_t              s2_side_next;
    logic [1:0][DIM_W-1:0]   s2_span_reg;
    logic [1:0][DIM_W-1:0]   s2_span_next;
    logic [1:0][DIM_W-1:0]   s2_dspan_reg;
    logic [1:0][DIM_W-1:0]   s2_dspan_next;
    logic [1:0][COORD_W-1:0] s2_doff_reg;
    logic [1:0][COORD_W-1:0] s2_doff_next;

    always_comb
    begin
        logic [COORD_W-1:0]  ea;
        logic [COORD_W-1:0]  eb;
        logic                lo;
        logic                hi;
        logic [SIGNED_W-1:0] span;
        logic                span_pos;
        for (int ax = 0; ax < 2; ax++)
        begin
            ea = s1_compact_reg ? BORDER : ax_a[ax];
            eb = s1_compact_reg ? BORDER : ax_b[ax];
            lo = ax_d[ax] < ea;
            hi = (DIM_W'(ax_d[ax]) + DIM_W'(eb)) >= ax_dn[ax];
            span = SIGNED_W'(ax_sn[ax]) - SIGNED_W'(ax_a[ax]) - SIGNED_W'(ax_b[ax]);
            span_pos = !span[SIGNED_W-1] && (span != '0);

            s2_side_next[ax].tiled = s1_compact_reg | tile_centre_reg;
            s2_side_next[ax].base  = ax_a[ax];
            s2_side_next[ax].corner = lo ? SIGNED_W'(ax_d[ax])
                : SIGNED_W'(ax_sn[ax]) - SIGNED_W'(ax_dn[ax]) + SIGNED_W'(ax_d[ax]);
            if (lo)
            begin
                s2_side_next[ax].region = RGN_LOW;
            end
            else if (hi)
            begin
                s2_side_next[ax].region = RGN_HIGH;
            end
            else if (span_pos)
            begin
                s2_side_next[ax].region = RGN_MID;
            end
            else
            begin
                s2_side_next[ax].region = RGN_FLAT;
            end

            s2_span_next[ax]  = span[DIM_W-1:0];
            s2_dspan_next[ax] = ax_dn[ax] - DIM_W'(ea) - DIM_W'(eb);
            s2_doff_next[ax]  = ax_d[ax] - ea;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg  <= s2_side_next;
        s2_span_reg  <= s2_span_next;
        s2_dspan_reg <= s2_dspan_next;
        s2_doff_reg  <= s2_doff_next;
    end

    // stage 3: stretch product and divider operands
    logic                  s3_valid_reg;
    side_pair_t            s3_side_reg;
    logic [1:0][NUM_W-1:0] s3_num_reg;
    logic [1:0][NUM_W-1:0] s3_num_next;
    logic [1:0][DIM_W-1:0] s3_den_reg;
    logic [1:0][DIM_W-1:0] s3_den_next;

    always_comb
    begin
        logic [COORD_W+DIM_W-1:0] prod;
        for (int ax = 0; ax < 2; ax++)
        begin
            prod = (COORD_W+DIM_W)'(s2_doff_reg[ax]) * (COORD_W+DIM_W)'(s2_span_reg[ax]);
            if (s2_side_reg[ax].region == RGN_MID)
            begin
                if (s2_side_reg[ax].tiled)
                begin
                    s3_num_next[ax] = NUM_W'(s2_doff_reg[ax]);
                    s3_den_next[ax] = s2_span_reg[ax];
                end
                else
                begin
                    s3_num_next[ax] = prod[NUM_W-1:0];
                    s3_den_next[ax] = s2_dspan_reg[ax];
                end
            end
            else
            begin
                s3_num_next[ax] = '0;
                s3_den_next[ax] = DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= s2_side_reg;
        s3_num_reg  <= s3_num_next;
        s3_den_reg  <= s3_den_next;
    end

    // stretch quotient or tile remainder
    logic                    div_valid;
    logic [1:0][COORD_W-1:0] div_quot;
    logic [1:0][COORD_W-1:0] div_rem;
    side_pair_t              div_side;

    nsta_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_num    (s3_num_reg),
        .in_den    (s3_den_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_rem   (div_rem),
        .out_side  (div_side)
    );

    // clamp stage: pick slice result and clamp to the texture
    logic                    s4_valid_reg;
    logic [1:0][COORD_W-1:0] s4_coord_reg;
    logic [1:0][COORD_W-1:0] s4_coord_next;

    always_comb
    begin
        logic [COORD_W-1:0]  off;
        logic [SIGNED_W-1:0] s;
        logic [SIGNED_W-1:0] limit;
        for (int ax = 0; ax < 2; ax++)
        begin
            off   = div_side[ax].tiled ? div_rem[ax] : div_quot[ax];
            limit = SIGNED_W'(ax_sn[ax]) - SIGNED_W'(1);
            case (div_side[ax].region)
                RGN_LOW:  s = div_side[ax].corner;
                RGN_HIGH: s = div_side[ax].corner;
                RGN_MID:  s = SIGNED_W'(div_side[ax].base) + SIGNED_W'(off);
                RGN_FLAT: s = SIGNED_W'(div_side[ax].base);
                default:  s = div_side[ax].corner;
            endcase
            if (s[SIGNED_W-1])
            begin
                s4_coord_next[ax] = '0;
            end
            else if (s > limit)
            begin
                s4_coord_next[ax] = limit[COORD_W-1:0];
            end
            else
            begin
                s4_coord_next[ax] = s[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_coord_reg <= s4_coord_next;
    end

    // output stage: linear address
    logic [COORD_W+DIM_W-1:0] address_full;
    logic                     done_reg;
    logic [COORD_W-1:0]       source_x_reg;
    logic [COORD_W-1:0]       source_y_reg;
    logic [ADDR_W-1:0]        source_address_reg;

    assign address_full = (COORD_W+DIM_W)'(s4_coord_reg[AXIS_Y]) * (COORD_W+DIM_W)'(sw_sat)
                        + (COORD_W+DIM_W)'(s4_coord_reg[AXIS_X]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        source_x_reg       <= s4_coord_reg[AXIS_X];
        source_y_reg       <= s4_coord_reg[AXIS_Y];
        source_address_reg <= address_full[ADDR_W-1:0];
    end

    assign done           = done_reg;
    assign source_x       = source_x_reg;
    assign source_y       = source_y_reg;
    assign source_address = source_address_reg;

    // checks
    logic [COORD_W+DIM_W-1:0] chk_address;

    assign chk_address = (COORD_W+DIM_W)'(source_y) * (COORD_W+DIM_W)'(sw_sat)
                       + (COORD_W+DIM_W)'(source_x);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without a matching start transfer");

    a_in_texture: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (DIM_W'(source_x) < sw_sat) && (DIM_W'(source_y) < sh_sat))
        else $error("texel coordinate outside the texture");

    a_address: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (source_address == chk_address[ADDR_W-1:0]))
        else $error("address does not match texel coordinate");

endmodule

@@ hdl/nsta_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsta_divider
// Pipelined restoring divider for both axes, one quotient bit per stage.
// The dividend must be below den * 2**COORD_W; quotient and remainder are
// COORD_W bits. Side data travels with each transfer.
// ----------------------------------------------------------------------------
module nsta_divider
    import nsta_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [1:0][NUM_W-1:0]          in_num,
    input  logic [1:0][DIM_W-1:0]          in_den,
    input  side_pair_t                     in_side,
    output logic                           out_valid,
    output logic [1:0][COORD_W-1:0]        out_quot,
    output logic [1:0][COORD_W-1:0]        out_rem,
    output side_pair_t                     out_side
);

    div_lane_t [1:0] lane_reg  [DIV_STAGES];
    div_lane_t [1:0] lane_next [DIV_STAGES];
    side_pair_t      side_reg  [DIV_STAGES];
    logic            valid_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        div_lane_t [1:0] lane_in;
        side_pair_t      side_in;
        logic            valid_in;

        // stage source: loaded dividend or previous stage
        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int ax = 0; ax < 2; ax++)
                begin
                    lane_in[ax].rem  = in_num[ax][NUM_W-1:COORD_W];
                    lane_in[ax].low  = in_num[ax][COORD_W-1:0];
                    lane_in[ax].quot = '0;
                    lane_in[ax].den  = in_den[ax];
                end
            end
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_follow
            assign lane_in  = lane_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // trial subtract of the shifted partial remainder
        always_comb
        begin
            logic [DIM_W-1:0] trial;
            for (int ax = 0; ax < 2; ax++)
            begin
                trial = {lane_in[ax].rem, lane_in[ax].low[COORD_W-1]};
                lane_next[k][ax].den = lane_in[ax].den;
                lane_next[k][ax].low = {lane_in[ax].low[COORD_W-2:0], 1'b0};
                if (trial >= lane_in[ax].den)
                begin
                    lane_next[k][ax].rem  = COORD_W'(trial - lane_in[ax].den);
                    lane_next[k][ax].quot = {lane_in[ax].quot[COORD_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[k][ax].rem  = trial[COORD_W-1:0];
                    lane_next[k][ax].quot = {lane_in[ax].quot[COORD_W-2:0], 1'b0};
                end
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            lane_reg[k] <= lane_next[k];
            side_reg[k] <= side_in;
        end
    end

    // last stage drives the outputs
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            out_quot[ax] = lane_reg[DIV_STAGES-1][ax].quot;
            out_rem[ax]  = lane_reg[DIV_STAGES-1][ax].rem;
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule
